@@ src/modal_resonator_bank_core_defines.svh @@
// assertion macros for the resonator bank core
`ifndef MODAL_RESONATOR_BANK_CORE_DEFINES_SVH
`define MODAL_RESONATOR_BANK_CORE_DEFINES_SVH
// property a implies b on the same edge, outside reset
`define MRB_ASSERT_IMPLY(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
// property a implies b on the next edge, outside reset
`define MRB_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`endif

@@ src/mrb_pkg.sv @@
// ----------------------------------------------------------------------------
// mrb_pkg
// shared types, codes and the excitation table of the resonator bank
// ----------------------------------------------------------------------------
package mrb_pkg;
    localparam logic [2:0] SEL_B1 = 3'd0;
    localparam logic [2:0] SEL_WE = 3'd1;
    localparam logic [2:0] SEL_A1 = 3'd2;
    localparam logic [2:0] SEL_A2 = 3'd3;
    localparam logic [2:0] SEL_WP = 3'd4;
    localparam logic REQ_COEF = 1'b0;
    localparam logic REQ_TICK = 1'b1;
    localparam logic CFG_NUM_MODES = 1'b0;
    localparam logic CFG_OUT_GAIN = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic start;     // clear accumulator, latch excitation
        logic rd;        // issue coefficient/state read for the mode index
        logic mul;       // advance one multiply slot
        logic fin;       // final gain multiply
        logic clr;       // zero the history entry of the mode index
    } mrb_cmd_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        else if (v < -64'sd2147483648) return 32'sh80000000;
        else return v[31:0];
    endfunction

    function automatic logic signed [31:0] excite(input logic [2:0] i);
        case (i)
            3'd0: excite = 32'sd0;
            3'd1: excite = 32'sd331173;
            3'd2: excite = 32'sd1130693;
            3'd3: excite = 32'sd1930219;
            3'd4: excite = 32'sd2261392;
            3'd5: excite = 32'sd1930219;
            3'd6: excite = 32'sd1130693;
            default: excite = 32'sd331173;
        endcase
    endfunction
endpackage

@@ src/modal_resonator_bank_core.sv @@
// ----------------------------------------------------------------------------
// modal_resonator_bank_core
// bank of two-pole resonators for modal string synthesis
// ----------------------------------------------------------------------------
// After reset the block zeroes the history of every mode before it takes its
// first transfer. A coefficient transfer is written straight into its memory
// without leaving the idle state. A tick runs over the N active modes: one shared
// 32x32 multiplier works seven slots per mode after a read state that fetches
// the mode's coefficients and history from its memories, and a final gain
// multiply closes the tick. The next item is taken while the result still
// waits on the master side; a finished tick holds until that result is gone.
module modal_resonator_bank_core #(
    parameter int MODES = 128,
    parameter int BURST_LEN = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // tdata: mode_index[6:0], coef_select[9:7], coef_value[41:10], strike[42]
    input  logic [47:0] s_tdata,
    // tuser: req_type
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // tdata: sample_out[31:0]
    output logic [31:0] m_tdata,
    // tuser: burst_active
    output logic m_tuser,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [31:0] cfg_wdata
);
    import mrb_pkg::*;
`include "modal_resonator_bank_core_defines.svh"

    localparam int IW = (MODES > 1) ? $clog2(MODES) : 1;

    logic [7:0] num_modes_reg;
    logic signed [31:0] gain_reg;
    mrb_cmd_t cmd;
    logic [IW-1:0] mode_idx;
    logic [2:0] slot;
    logic st_we, out_load, burst;
    logic signed [31:0] x, sample;
    logic coef_we;
    logic [6:0] mi;
    logic [2:0] sel;

    assign mi = s_tdata[6:0];
    assign sel = s_tdata[9:7];
    assign coef_we = s_tvalid && s_tready && (s_tuser == REQ_COEF)
                     && (sel <= SEL_WP) && (32'(mi) < MODES);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_modes_reg <= '0;
            gain_reg <= 32'sd268435456;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NUM_MODES: num_modes_reg <= cfg_wdata[7:0];
                default: gain_reg <= cfg_wdata;
            endcase
        end
    end

    mrb_ctrl #(.MODES(MODES), .BURST_LEN(BURST_LEN), .IW(IW)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_tick(s_tuser == REQ_TICK), .in_strike(s_tdata[42]),
        .num_modes(num_modes_reg), .cmd(cmd), .mode_idx(mode_idx), .slot(slot),
        .st_we(st_we), .x_out(x), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_burst(burst), .out_load(out_load)
    );

    mrb_datapath #(.MODES(MODES), .IW(IW)) u_dp (
        .aclk(aclk), .coef_we(coef_we), .coef_sel(sel), .coef_idx(IW'(mi)),
        .coef_val(s_tdata[41:10]), .cmd(cmd), .mode_idx(mode_idx), .slot(slot),
        .st_we(st_we), .x_in(x), .gain(gain_reg), .sample(sample)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata <= sample;
            m_tuser <= burst;
        end
    end

    `MRB_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `MRB_ASSERT_IMPLY(a_noload, aclk, aresetn, out_load, !m_tvalid || m_tready)
    `MRB_ASSERT_IMPLY(a_excl, aclk, aresetn, st_we, !cmd.fin)
endmodule

@@ src/mrb_datapath.sv @@
// ----------------------------------------------------------------------------
// mrb_datapath
// coefficient and state memories with one shared multiplier
// ----------------------------------------------------------------------------
module mrb_datapath #(
    parameter int MODES = 128,
    parameter int IW = 7
) (
    input  logic aclk,
    input  logic coef_we,
    input  logic [2:0] coef_sel,
    input  logic [IW-1:0] coef_idx,
    input  logic signed [31:0] coef_val,
    input  mrb_pkg::mrb_cmd_t cmd,
    input  logic [IW-1:0] mode_idx,
    input  logic [2:0] slot,
    input  logic st_we,
    input  logic signed [31:0] x_in,
    input  logic signed [31:0] gain,
    output logic signed [31:0] sample
);
    import mrb_pkg::*;

    logic signed [31:0] b1_mem [MODES];
    logic signed [31:0] we_mem [MODES];
    logic signed [31:0] a1_mem [MODES];
    logic signed [31:0] a2_mem [MODES];
    logic signed [31:0] wp_mem [MODES];
    logic signed [31:0] p1_mem [MODES];
    logic signed [31:0] p2_mem [MODES];
    logic signed [31:0] b1_reg, we_reg, a1_reg, a2_reg, wp_reg, p1_reg, p2_reg;
    logic signed [31:0] x_reg, g_reg, y_reg;
    logic signed [63:0] prod_reg, sum_reg, acc_reg;
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod_sh;

    // coefficient and state memory writes and registered reads
    always_ff @(posedge aclk) begin
        if (coef_we) begin
            unique case (coef_sel)
                SEL_B1: b1_mem[coef_idx] <= coef_val;
                SEL_WE: we_mem[coef_idx] <= coef_val;
                SEL_A1: a1_mem[coef_idx] <= coef_val;
                SEL_A2: a2_mem[coef_idx] <= coef_val;
                default: wp_mem[coef_idx] <= coef_val;
            endcase
        end
        if (cmd.rd) begin
            b1_reg <= b1_mem[mode_idx];
            we_reg <= we_mem[mode_idx];
            a1_reg <= a1_mem[mode_idx];
            a2_reg <= a2_mem[mode_idx];
            wp_reg <= wp_mem[mode_idx];
            p1_reg <= p1_mem[mode_idx];
            p2_reg <= p2_mem[mode_idx];
        end
        if (st_we) begin
            if (cmd.clr) begin
                p1_mem[mode_idx] <= '0;
                p2_mem[mode_idx] <= '0;
            end else begin
                p1_mem[mode_idx] <= y_reg;
                p2_mem[mode_idx] <= p1_reg;
            end
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        ma = b1_reg; mb = we_reg;
        if (cmd.fin) begin
            ma = sat32(acc_reg); mb = gain;
        end else begin
            case (slot)
                3'd0: begin ma = b1_reg; mb = we_reg; end
                3'd1: begin ma = a1_reg; mb = p1_reg; end
                3'd2: begin ma = g_reg; mb = x_reg; end
                3'd3: begin ma = a2_reg; mb = p2_reg; end
                default: begin ma = wp_reg; mb = y_reg; end
            endcase
        end
    end

    assign prod_sh = prod_reg >>> 28;

    // multiply, then consume the previous product per slot
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(ma) * 64'(mb);
        if (cmd.start) begin
            acc_reg <= '0;
            x_reg <= x_in;
        end
        if (cmd.mul) begin
            // slot names the product now registered from the slot before
            case (slot)
                3'd1: g_reg <= sat32(prod_sh);
                3'd2: sum_reg <= -prod_sh;
                3'd3: sum_reg <= sum_reg + prod_sh;
                3'd4: y_reg <= sat32(sum_reg - prod_sh);
                3'd6: acc_reg <= acc_reg + prod_sh;
                default: ;
            endcase
        end
    end

    // final output register, loaded from the registered gain product
    logic fin_d;
    logic signed [31:0] out_reg;
    always_ff @(posedge aclk) begin
        fin_d <= cmd.fin;
        if (fin_d) out_reg <= sat32(prod_sh);
    end
    assign sample = out_reg;
endmodule

@@ src/mrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrb_ctrl
// sequencer over modes and multiply slots, burst logic, history clearing
// ----------------------------------------------------------------------------
module mrb_ctrl #(
    parameter int MODES = 128,
    parameter int BURST_LEN = 8,
    parameter int IW = 7
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  logic in_tick,
    input  logic in_strike,
    input  logic [7:0] num_modes,
    output mrb_pkg::mrb_cmd_t cmd,
    output logic [IW-1:0] mode_idx,
    output logic [2:0] slot,
    output logic st_we,
    output logic signed [31:0] x_out,
    output logic out_valid,
    input  logic out_ready,
    output logic out_burst,
    output logic out_load
);
    import mrb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MUL = 3'd2;
    localparam logic [2:0] S_FIN = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;
    localparam logic [2:0] S_CLR = 3'd6;
    localparam int BW = $clog2(BURST_LEN + 1);
    localparam int CW = $clog2(MODES + 1);

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next, active;
    logic [2:0] slot_reg, slot_next;
    logic [BW-1:0] bcnt_reg, bcnt_next;
    logic bflag_reg, bflag_next;
    logic vld_reg, vld_next;
    logic signed [31:0] x_reg, x_next;
    logic accept;

    assign active = (32'(num_modes) > MODES) ? CW'(MODES) : CW'(num_modes);
    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign mode_idx = cnt_reg[IW-1:0];
    assign slot = slot_reg;
    assign x_out = x_next;
    assign out_valid = vld_reg;
    assign out_burst = bflag_reg;

    // sequencer and burst state
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        slot_next = slot_reg;
        bcnt_next = bcnt_reg;
        bflag_next = bflag_reg;
        x_next = x_reg;
        vld_next = vld_reg && !out_ready;
        cmd = '0;
        st_we = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            S_CLR: begin
                // zero one history entry per cycle after reset
                cmd.clr = 1'b1;
                st_we = 1'b1;
                if (cnt_reg == CW'(MODES - 1)) begin
                    cnt_next = '0;
                    state_next = S_IDLE;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_IDLE: begin
                if (accept && in_tick) begin
                    x_next = '0;
                    if (in_strike && !bflag_reg) begin
                        bflag_next = 1'b1;
                        bcnt_next = '0;
                    end
                    if (bflag_next) begin
                        x_next = excite(bcnt_next[2:0]);
                        if (bcnt_next + BW'(1) >= BW'(BURST_LEN)) begin
                            bflag_next = 1'b0;
                            bcnt_next = '0;
                        end else begin
                            bcnt_next = bcnt_next + BW'(1);
                        end
                    end
                    cmd.start = 1'b1;
                    cnt_next = '0;
                    state_next = (active == '0) ? S_FIN : S_READ;
                end
            end
            S_READ: begin
                cmd.rd = 1'b1;
                slot_next = 3'd0;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                slot_next = slot_reg + 3'd1;
                if (slot_reg == 3'd6) begin
                    st_we = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                    state_next = (cnt_next == active) ? S_FIN : S_READ;
                end
            end
            S_FIN: begin
                cmd.fin = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: state_next = S_DONE;
            S_DONE: begin
                // hold until the output register is free
                if (!vld_reg || out_ready) begin
                    out_load = 1'b1;
                    vld_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            cnt_reg <= '0;
            slot_reg <= '0;
            bcnt_reg <= '0;
            bflag_reg <= 1'b0;
            vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            slot_reg <= slot_next;
            bcnt_reg <= bcnt_next;
            bflag_reg <= bflag_next;
            vld_reg <= vld_next;
        end
        x_reg <= x_next;
    end
endmodule
